// File: rtl/cfc_pkg.sv
package cfc_pkg;

	// coordinate fields of one request
	localparam int COORD_W = 21;
	localparam int DIFF_W = COORD_W + 1;
	localparam int NUM_AXES = 3;
	localparam int IN_W = 128;
	localparam int OUT_W = 8;

	// matrix elements and plane coefficients
	localparam int ELEM_W = 32;
	localparam int COEF_W = ELEM_W + 1;
	localparam int NUM_COLS = 4;
	localparam int NUM_PLANES = 6;

	// configuration register file
	localparam int NUM_REGS = 8;
	localparam int REG_AW = 3;
	localparam int CFG_IDX_W = 4;
	localparam int CFG_DATA_W = 64;

	localparam int MASK_W = 6;

	typedef struct packed {
		logic               valid;
		logic               vis;
		logic [MASK_W-1:0]  mask;
	} ctl_t;

endpackage

// File: rtl/cfc_cell.sv
module cfc_cell #(
	parameter int CW = 26,
	parameter bit MINUS = 1'b0
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  en,
	input  logic signed [cfc_pkg::ELEM_W-1:0]     base [cfc_pkg::NUM_COLS],
	input  logic signed [cfc_pkg::ELEM_W-1:0]     other [cfc_pkg::NUM_COLS],
	input  cfc_pkg::ctl_t                         up_ctl,
	input  logic signed [CW-1:0]                  up_mn [cfc_pkg::NUM_AXES],
	input  logic signed [CW-1:0]                  up_mx [cfc_pkg::NUM_AXES],
	output cfc_pkg::ctl_t                         dn_ctl,
	output logic signed [CW-1:0]                  dn_mn [cfc_pkg::NUM_AXES],
	output logic signed [CW-1:0]                  dn_mx [cfc_pkg::NUM_AXES]
);

	localparam int PW = cfc_pkg::COEF_W + CW;
	localparam int DW = PW + 2;

	logic signed [cfc_pkg::COEF_W-1:0] coef_q [cfc_pkg::NUM_COLS];
	logic signed [CW-1:0]              sel [cfc_pkg::NUM_AXES];
	logic signed [DW-1:0]              plane_dist;

	logic                              vld_s1;
	logic                              vis_s1;
	logic [cfc_pkg::MASK_W-1:0]        mask_s1;
	logic signed [PW-1:0]              prod_s1 [cfc_pkg::NUM_AXES];
	logic signed [cfc_pkg::COEF_W-1:0] d_s1;
	logic signed [CW-1:0]              mn_s1 [cfc_pkg::NUM_AXES];
	logic signed [CW-1:0]              mx_s1 [cfc_pkg::NUM_AXES];

	logic                              vld_s2;
	logic                              vis_s2;
	logic [cfc_pkg::MASK_W-1:0]        mask_s2;
	logic signed [CW-1:0]              mn_s2 [cfc_pkg::NUM_AXES];
	logic signed [CW-1:0]              mx_s2 [cfc_pkg::NUM_AXES];

	// plane coefficients, row 3 plus or minus this plane's row
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int c = 0; c < cfc_pkg::NUM_COLS; c++) begin
				coef_q[c] <= '0;
			end
		end else begin
			for (int c = 0; c < cfc_pkg::NUM_COLS; c++) begin
				if (MINUS) begin
					coef_q[c] <= {base[c][cfc_pkg::ELEM_W-1], base[c]}
						- {other[c][cfc_pkg::ELEM_W-1], other[c]};
				end else begin
					coef_q[c] <= {base[c][cfc_pkg::ELEM_W-1], base[c]}
						+ {other[c][cfc_pkg::ELEM_W-1], other[c]};
				end
			end
		end
	end

	// positive vertex
	always_comb begin
		for (int a = 0; a < cfc_pkg::NUM_AXES; a++) begin
			sel[a] = coef_q[a][cfc_pkg::COEF_W-1] ? up_mn[a] : up_mx[a];
		end
	end

	always_comb begin
		plane_dist = {{(DW-cfc_pkg::COEF_W){d_s1[cfc_pkg::COEF_W-1]}}, d_s1};
		for (int a = 0; a < cfc_pkg::NUM_AXES; a++) begin
			plane_dist = plane_dist + {{(DW-PW){prod_s1[a][PW-1]}}, prod_s1[a]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else if (en) begin
			vld_s1 <= up_ctl.valid;
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			vis_s1  <= up_ctl.vis;
			mask_s1 <= up_ctl.mask;
			d_s1    <= coef_q[cfc_pkg::NUM_COLS-1];
			for (int a = 0; a < cfc_pkg::NUM_AXES; a++) begin
				prod_s1[a] <= coef_q[a] * sel[a];
				mn_s1[a]   <= up_mn[a];
				mx_s1[a]   <= up_mx[a];
			end
			vis_s2  <= vis_s1 & ~plane_dist[DW-1];
			mask_s2 <= mask_s1;
			mn_s2   <= mn_s1;
			mx_s2   <= mx_s1;
		end
	end

	assign dn_ctl = '{valid: vld_s2, vis: vis_s2, mask: mask_s2};
	assign dn_mn  = mn_s2;
	assign dn_mx  = mx_s2;

endmodule

// File: rtl/chunk_frustum_cull.sv
// channel  | direction | handshake          | payload
// ---------+-----------+--------------------+---------------------------------------------
// s_       | in        | s_tvalid/s_tready  | s_tdata: chunk xyz, player xyz (21 b each)
// m_       | out       | m_tvalid/m_tready  | m_tdata: in_view, face_mask
// cfg_     | in        | cfg_valid/cfg_ready| cfg_index, cfg_data (matrix register write)
//
// one request per cycle while m_ is not stalled; pipeline of two prep stages, six plane
// cells of two stages each (multiply, then sum) and an output register
// arst_n clears the matrix registers to zero and empties the pipeline
// a stall at m_ freezes every stage together; s_tready falls only while a result waits
module chunk_frustum_cull #(
	parameter int CHUNK_EDGE = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// chunk_x [20:0], chunk_y [41:21], chunk_z [62:42],
	// player_x [83:63], player_y [104:84], player_z [125:105], zero fill [127:126]
	input  logic [cfc_pkg::IN_W-1:0]          s_tdata,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	// in_view [0], face_mask [6:1], zero fill [7]
	output logic [cfc_pkg::OUT_W-1:0]         m_tdata,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [cfc_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [cfc_pkg::CFG_DATA_W-1:0]    cfg_data
);

	// box coordinate width: difference times edge, plus one edge
	localparam int CW = cfc_pkg::DIFF_W + $clog2(CHUNK_EDGE + 1);
	localparam logic signed [CW-1:0] EDGE_C = CW'(CHUNK_EDGE);

	// matrix registers, colC_rowsAB at index 2C + A/2
	logic [cfc_pkg::CFG_DATA_W-1:0] regs_q [cfc_pkg::NUM_REGS];

	logic en;

	logic signed [cfc_pkg::COORD_W-1:0] chunk_c [cfc_pkg::NUM_AXES];
	logic signed [cfc_pkg::COORD_W-1:0] player_c [cfc_pkg::NUM_AXES];

	// prep stage 1: per-axis difference and face mask
	logic                               valid_s1;
	logic signed [cfc_pkg::DIFF_W-1:0]  diff_s1 [cfc_pkg::NUM_AXES];
	logic [cfc_pkg::MASK_W-1:0]         mask_s1;
	logic [cfc_pkg::MASK_W-1:0]         mask_d;

	// prep stage 2: box relative to the player
	logic                               valid_s2;
	logic signed [CW-1:0]               mn_s2 [cfc_pkg::NUM_AXES];
	logic signed [CW-1:0]               mx_s2 [cfc_pkg::NUM_AXES];
	logic [cfc_pkg::MASK_W-1:0]         mask_s2;

	// cell chain taps
	cfc_pkg::ctl_t                      ch_ctl [cfc_pkg::NUM_PLANES+1];
	logic signed [CW-1:0]               ch_mn [cfc_pkg::NUM_PLANES+1][cfc_pkg::NUM_AXES];
	logic signed [CW-1:0]               ch_mx [cfc_pkg::NUM_PLANES+1][cfc_pkg::NUM_AXES];

	// matrix elements handed to the cells
	logic signed [cfc_pkg::ELEM_W-1:0]  col_base [cfc_pkg::NUM_COLS];
	logic signed [cfc_pkg::ELEM_W-1:0]  pl_other [cfc_pkg::NUM_PLANES][cfc_pkg::NUM_COLS];

	logic                               m_tvalid_q;
	logic [cfc_pkg::OUT_W-1:0]          m_tdata_q;

	// whole pipeline moves when the output register is free or being emptied
	assign en        = !m_tvalid_q || m_tready;
	assign s_tready  = en;
	assign cfg_ready = 1'b1;

	// configuration writes; an index past the register file is dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < cfc_pkg::NUM_REGS; i++) begin
				regs_q[i] <= '0;
			end
		end else if (cfg_valid && cfg_ready
			&& cfg_index < cfc_pkg::CFG_IDX_W'(cfc_pkg::NUM_REGS)) begin
			regs_q[cfg_index[cfc_pkg::REG_AW-1:0]] <= cfg_data;
		end
	end

	// row 3 sits in the high half of each colC_rows23 register
	for (genvar c = 0; c < cfc_pkg::NUM_COLS; c++) begin : g_col
		assign col_base[c] = regs_q[2*c+1][2*cfc_pkg::ELEM_W-1:cfc_pkg::ELEM_W];
		for (genvar p = 0; p < cfc_pkg::NUM_PLANES; p++) begin : g_pl
			localparam int ROW = p / 2;
			assign pl_other[p][c] =
				regs_q[2*c + ROW/2][cfc_pkg::ELEM_W*(ROW%2) +: cfc_pkg::ELEM_W];
		end
	end

	// unpack the request
	for (genvar a = 0; a < cfc_pkg::NUM_AXES; a++) begin : g_unpack
		assign chunk_c[a]  = s_tdata[a*cfc_pkg::COORD_W +: cfc_pkg::COORD_W];
		assign player_c[a] =
			s_tdata[(a+cfc_pkg::NUM_AXES)*cfc_pkg::COORD_W +: cfc_pkg::COORD_W];
	end

	// faces toward the player: plus face when chunk <= player, minus face when >=
	always_comb begin
		for (int a = 0; a < cfc_pkg::NUM_AXES; a++) begin
			mask_d[a]                    = (chunk_c[a] <= player_c[a]);
			mask_d[a+cfc_pkg::NUM_AXES]  = (chunk_c[a] >= player_c[a]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1   <= 1'b0;
			valid_s2   <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else if (en) begin
			valid_s1   <= s_tvalid;
			valid_s2   <= valid_s1;
			m_tvalid_q <= ch_ctl[cfc_pkg::NUM_PLANES].valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mask_s1 <= mask_d;
			mask_s2 <= mask_s1;
			for (int a = 0; a < cfc_pkg::NUM_AXES; a++) begin
				diff_s1[a] <= {chunk_c[a][cfc_pkg::COORD_W-1], chunk_c[a]}
					- {player_c[a][cfc_pkg::COORD_W-1], player_c[a]};
				// min corner = diff * edge, max corner one edge further
				mn_s2[a] <= CW'(diff_s1[a]) * EDGE_C;
				mx_s2[a] <= CW'(diff_s1[a]) * EDGE_C + EDGE_C;
			end
			m_tdata_q <= {1'b0, ch_ctl[cfc_pkg::NUM_PLANES].mask,
				ch_ctl[cfc_pkg::NUM_PLANES].vis};
		end
	end

	// head of the chain: in view until some plane says otherwise
	assign ch_ctl[0] = '{valid: valid_s2, vis: 1'b1, mask: mask_s2};
	assign ch_mn[0]  = mn_s2;
	assign ch_mx[0]  = mx_s2;

	// one cell per plane, order x plus, x minus, y plus, y minus, z plus, z minus
	for (genvar p = 0; p < cfc_pkg::NUM_PLANES; p++) begin : g_cell
		cfc_cell #(
			.CW    (CW),
			.MINUS (p % 2 == 1)
		) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (en),
			.base   (col_base),
			.other  (pl_other[p]),
			.up_ctl (ch_ctl[p]),
			.up_mn  (ch_mn[p]),
			.up_mx  (ch_mx[p]),
			.dn_ctl (ch_ctl[p+1]),
			.dn_mn  (ch_mn[p+1]),
			.dn_mx  (ch_mx[p+1])
		);
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	// a face on each axis always faces the player
	a_face_cover: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[1] || m_tdata[4]) && (m_tdata[2] || m_tdata[5])
			&& (m_tdata[3] || m_tdata[6]))
		else $error("face mask leaves an axis without a face");

	// an accepted request enters the first prep stage
	a_accept_enters: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> valid_s1)
		else $error("accepted request lost at entry");

	// a register write to index 0 lands in the register file
	a_cfg_write: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid && cfg_ready && cfg_index == '0 |=> regs_q[0] == $past(cfg_data))
		else $error("configuration write not stored");

endmodule

// File: sim/tb_chunk_frustum_cull.sv
module tb_chunk_frustum_cull;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CHUNK_EDGE = 16;
	// pipeline depth of the block, plus a little slack
	localparam int PIPE_LATENCY = 15;
	localparam int SETTLE_CYCLES = PIPE_LATENCY + 5;
	localparam int COORD_MAX = (1 << (cfc_pkg::COORD_W - 1)) - 1;
	localparam int COORD_MIN = -(1 << (cfc_pkg::COORD_W - 1));
	localparam int RANDOM_PHASES = 10;
	localparam int PHASE_REQUESTS = 170;
	localparam int HOLD_CYCLES = 400;
	// expectation ring, well above the requests the pipeline can hold
	localparam int EXP_AW = 6;
	localparam int EXP_DEPTH = 1 << EXP_AW;

	// matrix register map, column-major, two rows per register
	typedef enum logic [cfc_pkg::CFG_IDX_W-1:0] {
		REG_COL0_ROWS01,
		REG_COL0_ROWS23,
		REG_COL1_ROWS01,
		REG_COL1_ROWS23,
		REG_COL2_ROWS01,
		REG_COL2_ROWS23,
		REG_COL3_ROWS01,
		REG_COL3_ROWS23
	} mat_reg_e;

	typedef enum int {RX_ALWAYS, RX_RANDOM, RX_PATTERN} rx_mode_e;
	typedef enum int {TX_STREAM, TX_BURSTY} tx_mode_e;
	typedef enum int {MAT_VIEW, MAT_FULL, MAT_MAX, MAT_MIN, MAT_MIXED} mat_kind_e;

	// one request: last field in the lowest bits of tdata
	typedef struct packed {
		logic signed [cfc_pkg::COORD_W-1:0] pz;
		logic signed [cfc_pkg::COORD_W-1:0] py;
		logic signed [cfc_pkg::COORD_W-1:0] px;
		logic signed [cfc_pkg::COORD_W-1:0] cz;
		logic signed [cfc_pkg::COORD_W-1:0] cy;
		logic signed [cfc_pkg::COORD_W-1:0] cx;
	} chunk_req_t;

	typedef struct packed {
		logic                       in_view;
		logic [cfc_pkg::MASK_W-1:0] face_mask;
	} cull_res_t;

	logic                           clk = 1'b0;
	logic                           arst_n = 1'b0;
	logic [cfc_pkg::IN_W-1:0]       s_tdata = '0;
	logic                           s_tvalid = 1'b0;
	logic                           s_tready;
	logic [cfc_pkg::OUT_W-1:0]      m_tdata;
	logic                           m_tvalid;
	logic                           m_tready = 1'b0;
	logic                           cfg_valid = 1'b0;
	logic                           cfg_ready;
	logic [cfc_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
	logic [cfc_pkg::CFG_DATA_W-1:0] cfg_data = '0;

	// shadow of the matrix registers and the next matrix to load
	logic [cfc_pkg::CFG_DATA_W-1:0] mat_shadow [cfc_pkg::NUM_REGS];
	logic [cfc_pkg::CFG_DATA_W-1:0] mat_next [cfc_pkg::NUM_REGS];

	// expected results in request order
	cull_res_t exp_mem [EXP_DEPTH];
	int        exp_wr = 0;
	int        exp_rd = 0;
	int        mismatch_count = 0;

	rx_mode_e  rx_mode = RX_ALWAYS;
	tx_mode_e  tx_mode = TX_STREAM;
	int        burst_left = 0;
	bit        hold_req = 1'b0;
	int        hold_left = 0;
	int        rx_tick = 0;

	chunk_frustum_cull #(
		.CHUNK_EDGE(CHUNK_EDGE)
	) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tdata   (s_tdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.m_tdata   (m_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #10 clk = ~clk;

	// ---------------------------------------------------------------------
	// predictor
	// ---------------------------------------------------------------------

	// signed Q16.16 element at (row, col), widened to 64 bits
	function automatic longint mat_elem(int row, int col);
		logic [cfc_pkg::CFG_DATA_W-1:0] word;
		word = mat_shadow[col * 2 + row / 2];
		return (row % 2 != 0) ? longint'($signed(word[63:32])) : longint'($signed(word[31:0]));
	endfunction

	function automatic cull_res_t predict_cull(chunk_req_t req);
		longint    lo [cfc_pkg::NUM_AXES];
		longint    hi [cfc_pkg::NUM_AXES];
		longint    coef [cfc_pkg::NUM_COLS];
		longint    plane_dist;
		cull_res_t res;
		// box corners relative to the player's chunk
		lo[0] = (longint'(req.cx) - longint'(req.px)) * CHUNK_EDGE;
		lo[1] = (longint'(req.cy) - longint'(req.py)) * CHUNK_EDGE;
		lo[2] = (longint'(req.cz) - longint'(req.pz)) * CHUNK_EDGE;
		for (int a = 0; a < cfc_pkg::NUM_AXES; a++)
			hi[a] = lo[a] + CHUNK_EDGE;
		res.in_view = 1'b1;
		// planes: row 3 plus, then minus, rows 0 to 2 in turn
		for (int p = 0; p < cfc_pkg::NUM_PLANES; p++) begin
			for (int c = 0; c < cfc_pkg::NUM_COLS; c++) begin
				if (p % 2 != 0)
					coef[c] = mat_elem(3, c) - mat_elem(p / 2, c);
				else
					coef[c] = mat_elem(3, c) + mat_elem(p / 2, c);
			end
			// positive vertex: min corner only for a negative coefficient
			plane_dist = coef[3];
			for (int a = 0; a < cfc_pkg::NUM_AXES; a++)
				plane_dist += coef[a] * ((coef[a] < 0) ? lo[a] : hi[a]);
			if (plane_dist < 0)
				res.in_view = 1'b0;
		end
		res.face_mask = {req.cz >= req.pz, req.cy >= req.py, req.cx >= req.px,
			req.cz <= req.pz, req.cy <= req.py, req.cx <= req.px};
		return res;
	endfunction

	function automatic int exp_pending();
		return exp_wr - exp_rd;
	endfunction

	// ---------------------------------------------------------------------
	// stimulus helpers
	// ---------------------------------------------------------------------

	function automatic chunk_req_t make_chunk(int cx, int cy, int cz, int px, int py, int pz);
		chunk_req_t req;
		req.cx = cfc_pkg::COORD_W'(cx);
		req.cy = cfc_pkg::COORD_W'(cy);
		req.cz = cfc_pkg::COORD_W'(cz);
		req.px = cfc_pkg::COORD_W'(px);
		req.py = cfc_pkg::COORD_W'(py);
		req.pz = cfc_pkg::COORD_W'(pz);
		return req;
	endfunction

	// mostly chunks around the player, some anywhere in the world
	function automatic chunk_req_t random_chunk();
		chunk_req_t req;
		int         reach;
		req.px = cfc_pkg::COORD_W'($urandom);
		req.py = cfc_pkg::COORD_W'($urandom);
		req.pz = cfc_pkg::COORD_W'($urandom);
		if ($urandom_range(0, 99) < 20) begin
			req.cx = cfc_pkg::COORD_W'($urandom);
			req.cy = cfc_pkg::COORD_W'($urandom);
			req.cz = cfc_pkg::COORD_W'($urandom);
		end else begin
			reach = ($urandom_range(0, 3) == 0) ? 2 : 24;
			req.cx = req.px + cfc_pkg::COORD_W'(int'($urandom_range(0, 2 * reach)) - reach);
			req.cy = req.py + cfc_pkg::COORD_W'(int'($urandom_range(0, 2 * reach)) - reach);
			req.cz = req.pz + cfc_pkg::COORD_W'(int'($urandom_range(0, 2 * reach)) - reach);
		end
		return req;
	endfunction

	// one request; valid stays high unless a burst gap follows
	task automatic send_chunk(input chunk_req_t req);
		s_tdata  <= cfc_pkg::IN_W'(req);
		s_tvalid <= 1'b1;
		do @(posedge clk); while (!s_tready);
		exp_mem[EXP_AW'(exp_wr)] = predict_cull(req);
		exp_wr++;
		if (tx_mode == TX_BURSTY) begin
			if (burst_left == 0) begin
				burst_left = $urandom_range(1, 16);
				s_tvalid <= 1'b0;
				repeat ($urandom_range(1, 24)) @(posedge clk);
			end else begin
				burst_left--;
			end
		end
	endtask

	task automatic wait_drained();
		while (exp_pending() != 0)
			@(posedge clk);
	endtask

	// matrix writes only with the pipeline empty
	task automatic load_matrix();
		logic [cfc_pkg::CFG_DATA_W-1:0] word;
		s_tvalid <= 1'b0;
		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		// an index past the register file must leave the matrix alone
		word = {$urandom, $urandom};
		cfg_index <= cfc_pkg::CFG_IDX_W'(cfc_pkg::NUM_REGS
			+ $urandom_range(0, cfc_pkg::NUM_REGS - 1));
		cfg_data  <= word;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		for (int i = 0; i < cfc_pkg::NUM_REGS; i++) begin
			cfg_index <= mat_reg_e'(i);
			cfg_data  <= mat_next[i];
			cfg_valid <= 1'b1;
			do @(posedge clk); while (!cfg_ready);
			mat_shadow[i] = mat_next[i];
		end
		cfg_valid <= 1'b0;
	endtask

	function automatic logic [31:0] random_half(mat_kind_e kind, int col);
		logic [31:0] half;
		case (kind)
			MAT_VIEW: begin
				// projection-like scale terms, larger translation terms
				if (col == 3)
					half = $urandom_range(0, 1 << 23) - (1 << 22);
				else
					half = $urandom_range(0, 1 << 18) - (1 << 17);
			end
			MAT_MAX: half = 32'h7fff_ffff;
			MAT_MIN: half = 32'h8000_0000;
			MAT_MIXED: begin
				case ($urandom_range(0, 4))
					0: half = 32'h7fff_ffff;
					1: half = 32'h8000_0000;
					2: half = 32'h0000_0000;
					3: half = 32'hffff_ffff;
					default: half = 32'h0000_0001;
				endcase
			end
			default: half = $urandom;
		endcase
		return half;
	endfunction

	task automatic build_matrix(input mat_kind_e kind);
		for (int i = 0; i < cfc_pkg::NUM_REGS; i++)
			mat_next[i] = {random_half(kind, i / 2), random_half(kind, i / 2)};
	endtask

	// ---------------------------------------------------------------------
	// tests
	// ---------------------------------------------------------------------

	// zero matrix after reset: every plane passes, only the face mask varies
	task automatic test_zero_matrix();
		send_chunk(make_chunk(0, 0, 0, 0, 0, 0));
		send_chunk(make_chunk(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, COORD_MAX));
		send_chunk(make_chunk(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MIN, COORD_MIN, COORD_MIN));
		send_chunk(make_chunk(COORD_MAX, COORD_MIN, 5, COORD_MIN, COORD_MAX, 5));
		send_chunk(make_chunk(-1, 0, 1, 0, 0, 0));
		send_chunk(make_chunk(-1, -1, -1, -1, -1, -1));
	endtask

	// single x term in row 3: distances land exactly on zero at the box edge
	task automatic test_plane_edges();
		foreach (mat_next[i])
			mat_next[i] = '0;
		mat_next[REG_COL0_ROWS23] = {32'h0000_0001, 32'h0000_0000};
		load_matrix();
		send_chunk(make_chunk(-1, 0, 0, 0, 0, 0)); // zero distance counts as inside
		send_chunk(make_chunk(-2, 0, 0, 0, 0, 0));
		send_chunk(make_chunk(0, 3, -3, 0, 0, 0)); // zero coefficients on y and z
		// negative coefficient takes the min corner
		mat_next[REG_COL0_ROWS23] = {32'hffff_ffff, 32'h0000_0000};
		load_matrix();
		send_chunk(make_chunk(1, 0, 0, 0, 0, 0));
		send_chunk(make_chunk(0, 0, 0, 0, 0, 0));
		send_chunk(make_chunk(-1, 0, 0, 0, 0, 0));
		// row 0 term flips the sign of the minus plane only
		mat_next[REG_COL0_ROWS23] = {32'h0000_0001, 32'h0000_0000};
		mat_next[REG_COL0_ROWS01] = {32'h0000_0000, 32'h0000_0002};
		load_matrix();
		send_chunk(make_chunk(0, 0, 0, 0, 0, 0));
		send_chunk(make_chunk(-1, 0, 0, 0, 0, 0));
		send_chunk(make_chunk(1, 0, 0, 0, 0, 0));
	endtask

	// full-scale coefficients against the widest chunk offsets
	task automatic test_extreme_matrix();
		build_matrix(MAT_MAX);
		load_matrix();
		send_chunk(make_chunk(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, COORD_MAX));
		send_chunk(make_chunk(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MIN, COORD_MIN, COORD_MIN));
		send_chunk(make_chunk(COORD_MAX, COORD_MIN, COORD_MAX, COORD_MIN, COORD_MAX, COORD_MIN));
		send_chunk(make_chunk(0, 0, 0, 0, 0, 0));
		build_matrix(MAT_MIN);
		load_matrix();
		send_chunk(make_chunk(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, COORD_MAX));
		send_chunk(make_chunk(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MIN, COORD_MIN, COORD_MIN));
		send_chunk(make_chunk(COORD_MIN, COORD_MAX, COORD_MIN, COORD_MAX, COORD_MIN, COORD_MAX));
		send_chunk(make_chunk(0, 0, 0, 0, 0, 0));
	endtask

	// a new matrix per phase, idling style rotating between phases
	task automatic test_random_views();
		mat_kind_e kind;
		for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
			case (ph)
				0, 2, 4, 6: kind = MAT_VIEW;
				1, 5: kind = MAT_FULL;
				3: kind = MAT_MIXED;
				7: kind = MAT_MAX;
				8: kind = MAT_MIN;
				default: kind = MAT_MIXED;
			endcase
			build_matrix(kind);
			load_matrix();
			rx_mode = rx_mode_e'(ph % 3);
			tx_mode = (ph % 4 == 0) ? TX_STREAM : TX_BURSTY;
			repeat (PHASE_REQUESTS)
				send_chunk(random_chunk());
		end
	endtask

	// receiver holds off for a long stretch while requests keep coming
	task automatic test_output_hold();
		build_matrix(MAT_VIEW);
		load_matrix();
		rx_mode = RX_ALWAYS;
		tx_mode = TX_STREAM;
		hold_req = 1'b1;
		repeat (80)
			send_chunk(random_chunk());
	endtask

	// sender pauses until every result is back, then resumes
	task automatic test_drain_pause();
		rx_mode = RX_RANDOM;
		tx_mode = TX_BURSTY;
		repeat (40)
			send_chunk(random_chunk());
		s_tvalid <= 1'b0;
		wait_drained();
		repeat (40)
			send_chunk(random_chunk());
	endtask

	// ---------------------------------------------------------------------
	// receiver: own stall pattern, plus a counted hold-off on request
	// ---------------------------------------------------------------------
	always @(posedge clk) begin
		rx_tick <= rx_tick + 1;
		if (hold_req) begin
			hold_req = 1'b0;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left = hold_left - 1;
			m_tready <= 1'b0;
		end else begin
			case (rx_mode)
				RX_RANDOM: m_tready <= ($urandom_range(0, 99) < 65);
				RX_PATTERN: m_tready <= (rx_tick % 11 < 7) && (rx_tick % 5 != 0);
				default: m_tready <= 1'b1;
			endcase
		end
	end

	// ---------------------------------------------------------------------
	// result check against the oldest expectation
	// ---------------------------------------------------------------------
	always @(posedge clk) begin : result_check
		cull_res_t want;
		if (m_tvalid && m_tready) begin
			if (exp_pending() == 0) begin
				mismatch_count++;
				$display("%0t: unexpected result expected none actual in_view %0b face_mask %02h",
					$time, m_tdata[0], m_tdata[cfc_pkg::MASK_W:1]);
			end else begin
				want = exp_mem[EXP_AW'(exp_rd)];
				exp_rd++;
				if (m_tdata[0] !== want.in_view) begin
					mismatch_count++;
					$display("%0t: in_view mismatch expected %0b actual %0b",
						$time, want.in_view, m_tdata[0]);
				end
				if (m_tdata[cfc_pkg::MASK_W:1] !== want.face_mask) begin
					mismatch_count++;
					$display("%0t: face_mask mismatch expected %02h actual %02h",
						$time, want.face_mask, m_tdata[cfc_pkg::MASK_W:1]);
				end
			end
		end
	end

	// ---------------------------------------------------------------------
	// test sequence
	// ---------------------------------------------------------------------
	initial begin
		foreach (mat_shadow[i])
			mat_shadow[i] = '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_zero_matrix();
		test_plane_edges();
		test_extreme_matrix();
		test_random_views();
		test_output_hold();
		test_drain_pause();

		// let the pipeline empty, bounded
		s_tvalid <= 1'b0;
		for (int n = 0; n < 20000 && exp_pending() != 0; n++)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (exp_pending() != 0) begin
			mismatch_count++;
			$display("%0t: results missing expected %0d more actual 0",
				$time, exp_pending());
		end

		if (mismatch_count == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

	// run limit, well above the slowest legal run
	initial begin
		#5_000_000;
		$display("simulation failed");
		$finish;
	end

endmodule
